[hw/rtl/tsfb_pkg.sv]
// shared types and constants for the timestamped store-and-forward buffer
// no dependencies
package tsfb_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 10;

  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [4:0] DAY_LAST  = 5'd30;
  localparam logic [3:0] MON_LAST  = 4'd11;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } stamp_t;

  typedef struct packed {
    stamp_t      stamp;
    logic [15:0] value;
  } rec_t;

  // ring status toward the output stage
  typedef struct packed {
    logic fwd;
    rec_t oldest;
  } ring_status_t;

endpackage

[hw/rtl/tsfb_clock.sv]
// one-second calendar counter: seconds, minutes, hours, days, months, year
// depends on tsfb_pkg
module tsfb_clock import tsfb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   tick_i,
  output stamp_t stamp_o
);

  stamp_t stamp_q, stamp_d;

  always_comb begin
    stamp_d = stamp_q;
    if (stamp_q.seconds == SEC_LAST) begin
      stamp_d.seconds = '0;
      if (stamp_q.minutes == MIN_LAST) begin
        stamp_d.minutes = '0;
        if (stamp_q.hours == HOUR_LAST) begin
          stamp_d.hours = '0;
          if (stamp_q.day == DAY_LAST) begin
            stamp_d.day = '0;
            if (stamp_q.month == MON_LAST) begin
              stamp_d.month = '0;
              stamp_d.year  = stamp_q.year + 16'd1;
            end else begin
              stamp_d.month = stamp_q.month + 4'd1;
            end
          end else begin
            stamp_d.day = stamp_q.day + 5'd1;
          end
        end else begin
          stamp_d.hours = stamp_q.hours + 5'd1;
        end
      end else begin
        stamp_d.minutes = stamp_q.minutes + 6'd1;
      end
    end else begin
      stamp_d.seconds = stamp_q.seconds + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
    end else if (tick_i) begin
      stamp_q <= stamp_d;
    end
  end

  // live stamp is the advanced time
  assign stamp_o = stamp_d;

endmodule

[hw/rtl/tsfb_ring.sv]
// record ring with overwrite: occupancy flags, pointers and record memory
// depends on tsfb_pkg
module tsfb_ring import tsfb_pkg::*; #(
  parameter int unsigned Depth = STORE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         link_ready_i,
  input  rec_t         live_i,
  output ring_status_t status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  rec_t             mem [Depth];
  rec_t             rd_q;
  logic [Depth-1:0] full_q, full_d;
  logic [PtrW-1:0]  wr_q, wr_d, old_q, old_d, wr_slot;
  logic             we;

  assign wr_slot = ptr_next(wr_q);

  always_comb begin
    full_d = full_q;
    wr_d   = wr_q;
    old_d  = old_q;
    we     = 1'b0;
    if (step_i) begin
      if (link_ready_i) begin
        if (full_q[old_q]) begin
          full_d[old_q] = 1'b0;
          old_d         = ptr_next(old_q);
        end
      end else begin
        wr_d = wr_slot;
        we   = 1'b1;
        if (wr_slot == old_q && full_q[wr_slot]) begin
          old_d = ptr_next(wr_slot);
        end
        full_d[wr_slot] = (live_i.value != 16'd0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
      wr_q   <= PtrLast;
      old_q  <= '0;
    end else begin
      full_q <= full_d;
      wr_q   <= wr_d;
      old_q  <= old_d;
    end
  end

  // rd_q always holds the record at the oldest slot
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_slot] <= live_i;
    end
    if (we && wr_slot == old_d) begin
      rd_q <= live_i;
    end else begin
      rd_q <= mem[old_d];
    end
  end

  assign status_o.fwd    = full_q[old_q];
  assign status_o.oldest = rd_q;

endmodule

[hw/rtl/timestamped_store_and_forward_buffer.sv]
// Timestamped store-and-forward buffer. Each accepted reading advances a
// one-second calendar stamp; with the link up the oldest stored record is
// forwarded (or the live reading sent if the oldest slot holds no record), with
// the link down the stamped reading goes into a STORE_DEPTH-entry ring that
// overwrites its oldest record when full. Exactly one result per reading; a new
// reading is taken every cycle while the output register is free or being
// drained, and its result is registered for the cycle after it is taken.
// depends on tsfb_pkg, tsfb_clock, tsfb_ring
module timestamped_store_and_forward_buffer import tsfb_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // reading_value
  input  logic        s_axis_tuser,  // link_ready
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // send_valid, sent_value, sent_seconds, sent_minutes, sent_hours, sent_day,
  // sent_month, sent_year, next_interval, zero fill
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser   // from_store
);

  logic         step;
  stamp_t       now;
  rec_t         live;
  ring_status_t ring;
  logic         out_valid_q;
  logic [63:0]  data_q, data_d;
  logic         user_q, user_d;
  rec_t         sel;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  tsfb_clock u_clock (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (step),
    .stamp_o (now)
  );

  assign live.value = s_axis_tdata;
  assign live.stamp = now;

  tsfb_ring #(.Depth(STORE_DEPTH)) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .link_ready_i (s_axis_tuser),
    .live_i       (live),
    .status_o     (ring)
  );

  always_comb begin
    sel    = ring.fwd ? ring.oldest : live;
    data_d = '0;
    user_d = 1'b0;
    if (s_axis_tuser) begin
      data_d[0]     = 1'b1;
      data_d[16:1]  = sel.value;
      data_d[22:17] = sel.stamp.seconds;
      data_d[28:23] = sel.stamp.minutes;
      data_d[33:29] = sel.stamp.hours;
      data_d[38:34] = sel.stamp.day;
      data_d[42:39] = sel.stamp.month;
      data_d[58:43] = sel.stamp.year;
      data_d[59]    = !ring.fwd;
      user_d        = ring.fwd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

endmodule

[hw/rtl/tsfb_checker.sv]
// port-level checks for the timestamped store-and-forward buffer
// depends on timestamped_store_and_forward_buffer, bound below
module tsfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted reading gave no result");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata == 64'd0 && !m_axis_tuser)
    else $error("nonzero fields on a result with nothing sent");

  a_stored_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[0] && !m_axis_tdata[59]
      && m_axis_tdata[16:1] != 16'd0)
    else $error("bad forwarded record");

endmodule

bind timestamped_store_and_forward_buffer tsfb_checker u_tsfb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
